// ----- hw/rtl/atl_pkg.sv -----
// Package for the accelerometer tilt-angle block: widths, defaults and the
// arctangent table. No dependencies.
package atl_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int CORDIC_STAGES   = 16;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int MAX_STAGES      = 24;
	localparam int GUARD_BITS      = 8;
	localparam int ACC_FRAC        = 24;
	localparam int ZW              = 33;
	localparam int PITCH_W         = 18;
	localparam int ROLL_W          = 16;
	localparam int SERVO_W         = 8;
	localparam int OFFSET_W        = 8;
	localparam int OFFSET_RESET    = 90;
	localparam int SERVO_TOP       = 180;

	// atan(2^-i) in degrees, 24 fractional bits
	localparam logic [31:0] ATAN_TAB [0:MAX_STAGES-1] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	typedef struct packed {
		logic valid;
		logic zero;
	} atl_tag_t;

endpackage

// ----- hw/rtl/atl_if.sv -----
// Handshake channels of the tilt-angle block: sample, result and config.
// Depends on atl_pkg.
interface atl_smp_if #(parameter int SB = atl_pkg::SAMPLE_BITS);
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] accel_x;
	logic signed [SB-1:0] accel_y;
	logic signed [SB-1:0] accel_z;
	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atl_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [atl_pkg::PITCH_W-1:0]  pitch_q8;
	logic signed [atl_pkg::ROLL_W-1:0]   roll_q8;
	logic                                servo_valid;
	logic        [atl_pkg::SERVO_W-1:0]  servo_angle;
	modport source (output valid, pitch_q8, roll_q8, servo_valid, servo_angle,
		input ready);
	modport sink   (input valid, pitch_q8, roll_q8, servo_valid, servo_angle,
		output ready);
endinterface

interface atl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [atl_pkg::OFFSET_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/accel_tilt_angles.sv -----
// Tilt angles (pitch with offset, roll) from a three-axis accelerometer sample.
// Registered steps in order: sample capture, squares and sums, square root, CORDIC, result.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds while the result register is full and not taken.
// Reset clears every valid bit and sets the pitch offset to 90 degrees.
// Depends on atl_pkg, atl_if, atl_sqrt and atl_cordic.
module accel_tilt_angles #(
	parameter int SAMPLE_BITS     = atl_pkg::SAMPLE_BITS,
	parameter int CORDIC_STAGES   = atl_pkg::CORDIC_STAGES,
	parameter int ANGLE_FRAC_BITS = atl_pkg::ANGLE_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	atl_smp_if.sink    smp,
	atl_res_if.source  res,
	atl_cfg_if.sink    cfg
);
	localparam int SB = SAMPLE_BITS;
	localparam int RW = SB + atl_pkg::GUARD_BITS;
	localparam int ZW = atl_pkg::ZW;
	localparam int TW = $bits(atl_pkg::atl_tag_t);
	localparam int SH = atl_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH-1);
	localparam logic signed [ZW-1:0] TOP  = ZW'(atl_pkg::SERVO_TOP) <<< ANGLE_FRAC_BITS;

	logic en;
	logic [atl_pkg::OFFSET_W-1:0] offset_q;

	// advance whenever the result register is free or being taken
	assign en        = !res.valid || res.ready;
	assign smp.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= atl_pkg::OFFSET_W'(atl_pkg::OFFSET_RESET);
		end else if (cfg.valid) begin
			offset_q <= cfg.data;
		end
	end

	// stage 1: capture sample
	atl_pkg::atl_tag_t    tag_s1;
	logic signed [SB-1:0] ax_s1, ay_s1, az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.valid <= smp.valid;
			tag_s1.zero  <= (smp.accel_x == '0) && (smp.accel_y == '0) &&
				(smp.accel_z == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= smp.accel_x;
			ay_s1 <= smp.accel_y;
			az_s1 <= smp.accel_z;
		end
	end

	// stage 2: squares and sums
	logic signed [2*SB-1:0] axx, ayy, azz;
	atl_pkg::atl_tag_t      tag_s2;
	logic [2*SB-1:0]        sqp_s2, sqr_s2;
	logic signed [SB-1:0]   ax_s2, ay_s2;

	assign axx = ax_s1 * ax_s1;
	assign ayy = ay_s1 * ay_s1;
	assign azz = az_s1 * az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqp_s2 <= $unsigned(ayy) + $unsigned(azz);
			sqr_s2 <= $unsigned(axx) + $unsigned(azz);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
		end
	end

	// square roots
	logic [RW-1:0]        rootp, rootr;
	logic [TW+SB-1:0]     passp;
	logic [TW+SB-1:0]     passr;

	atl_sqrt #(.SB(SB), .PW(TW+SB)) u_sqrt_pitch (
		.clk(clk), .arst_n(arst_n), .en(en),
		.sq(sqp_s2), .pass_in({tag_s2, ax_s2}),
		.root(rootp), .pass_out(passp)
	);

	atl_sqrt #(.SB(SB), .PW(TW+SB)) u_sqrt_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.sq(sqr_s2), .pass_in({tag_s2, ay_s2}),
		.root(rootr), .pass_out(passr)
	);

	// arctangents
	logic signed [ZW-1:0] zp, zr;
	atl_pkg::atl_tag_t    tagp, tagr;

	atl_cordic #(.SB(SB), .NS(CORDIC_STAGES), .PW(TW)) u_cordic_pitch (
		.clk(clk), .arst_n(arst_n), .en(en),
		.root(rootp), .num($signed(passp[SB-1:0])), .pass_in(passp[TW+SB-1:SB]),
		.z(zp), .pass_out(tagp)
	);

	atl_cordic #(.SB(SB), .NS(CORDIC_STAGES), .PW(TW)) u_cordic_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.root(rootr), .num($signed(passr[SB-1:0])), .pass_in(passr[TW+SB-1:SB]),
		.z(zr), .pass_out(tagr)
	);

	// final stage: round, add offset, servo range check
	logic signed [ZW-1:0] pr, rr, pitch;
	logic                 sv;

	always_comb begin
		pr    = (zp + HALF) >>> SH;
		rr    = (zr + HALF) >>> SH;
		pitch = pr + ($signed({{(ZW-atl_pkg::OFFSET_W){1'b0}}, offset_q})
			<<< ANGLE_FRAC_BITS);
		sv    = !tagp.zero && (pitch > 0) && (pitch < TOP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (en) begin
			res.valid <= tagp.valid && tagr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.pitch_q8    <= tagp.zero ? '0 : pitch[atl_pkg::PITCH_W-1:0];
			res.roll_q8     <= tagr.zero ? '0 : rr[atl_pkg::ROLL_W-1:0];
			res.servo_valid <= sv;
			res.servo_angle <= sv ?
				pitch[ANGLE_FRAC_BITS +: atl_pkg::SERVO_W] : '0;
		end
	end
endmodule

// ----- hw/rtl/atl_sqrt.sv -----
// Pipelined integer square root of (sq << 2*GUARD_BITS), one result bit per
// stage, with a passenger word carried alongside. Depends on atl_pkg.
module atl_sqrt #(
	parameter int SB = atl_pkg::SAMPLE_BITS,
	parameter int PW = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [2*SB-1:0]                    sq,
	input  logic [PW-1:0]                      pass_in,
	output logic [SB+atl_pkg::GUARD_BITS-1:0]  root,
	output logic [PW-1:0]                      pass_out
);
	localparam int NW = 2*SB + 2*atl_pkg::GUARD_BITS;
	localparam int RW = NW/2;

	logic [NW-1:0] n_s    [0:RW];
	logic [NW-1:0] r_s    [0:RW];
	logic [PW-1:0] pass_s [0:RW];

	assign n_s[0]    = {sq, {(2*atl_pkg::GUARD_BITS){1'b0}}};
	assign r_s[0]    = '0;
	assign pass_s[0] = pass_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam logic [NW-1:0] B = NW'(1) << (NW-2-2*k);
		logic [NW:0]   trial;
		logic [NW-1:0] n_nx;
		logic [NW-1:0] r_nx;

		always_comb begin
			trial = {1'b0, r_s[k]} + {1'b0, B};
			if ({1'b0, n_s[k]} >= trial) begin
				n_nx = n_s[k] - trial[NW-1:0];
				r_nx = (r_s[k] >> 1) + B;
			end else begin
				n_nx = n_s[k];
				r_nx = r_s[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pass_s[k+1] <= '0;
			end else if (en) begin
				pass_s[k+1] <= pass_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_nx;
				r_s[k+1] <= r_nx;
			end
		end
	end

	assign root     = r_s[RW][RW-1:0];
	assign pass_out = pass_s[RW];
endmodule

// ----- hw/rtl/atl_cordic.sv -----
// Pipelined CORDIC vectoring arctangent in degrees (24 fractional bits),
// one micro-rotation per stage. Depends on atl_pkg.
module atl_cordic #(
	parameter int SB = atl_pkg::SAMPLE_BITS,
	parameter int NS = atl_pkg::CORDIC_STAGES,
	parameter int PW = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [SB+atl_pkg::GUARD_BITS-1:0]  root,
	input  logic signed [SB-1:0]               num,
	input  logic [PW-1:0]                      pass_in,
	output logic signed [atl_pkg::ZW-1:0]      z,
	output logic [PW-1:0]                      pass_out
);
	localparam int XW = SB + atl_pkg::GUARD_BITS + 3;
	localparam int RW = SB + atl_pkg::GUARD_BITS;
	localparam int ZW = atl_pkg::ZW;

	logic signed [XW-1:0] x_s    [0:NS];
	logic signed [XW-1:0] y_s    [0:NS];
	logic signed [ZW-1:0] z_s    [0:NS];
	logic [PW-1:0]        pass_s [0:NS];

	assign x_s[0]    = $signed({{(XW-RW){1'b0}}, root});
	assign y_s[0]    = $signed({{(XW-SB){num[SB-1]}}, num}) <<< atl_pkg::GUARD_BITS;
	assign z_s[0]    = '0;
	assign pass_s[0] = pass_in;

	for (genvar i = 0; i < NS; i++) begin : g_stage
		localparam logic signed [ZW-1:0] A = $signed({{(ZW-32){1'b0}},
			atl_pkg::ATAN_TAB[i]});
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic signed [XW-1:0] x_nx;
		logic signed [XW-1:0] y_nx;
		logic signed [ZW-1:0] z_nx;

		always_comb begin
			xs = x_s[i] >>> i;
			ys = y_s[i] >>> i;
			x_nx = x_s[i];
			y_nx = y_s[i];
			z_nx = z_s[i];
			// rotate towards y = 0; hold when already there
			if (y_s[i] > 0) begin
				x_nx = x_s[i] + ys;
				y_nx = y_s[i] - xs;
				z_nx = z_s[i] + A;
			end else if (y_s[i] < 0) begin
				x_nx = x_s[i] - ys;
				y_nx = y_s[i] + xs;
				z_nx = z_s[i] - A;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pass_s[i+1] <= '0;
			end else if (en) begin
				pass_s[i+1] <= pass_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1] <= x_nx;
				y_s[i+1] <= y_nx;
				z_s[i+1] <= z_nx;
			end
		end
	end

	assign z        = z_s[NS];
	assign pass_out = pass_s[NS];
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for accel_tilt_angles: directed table, the table again at
// other offsets, then random samples checked against an in-bench square-root and
// CORDIC tilt predictor. Depends on atl_pkg, atl_if and the accel_tilt_angles RTL.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		logic signed [15:0] ax, ay, az;
		bit                 typed;
		logic signed [17:0] pitch;
		logic signed [15:0] roll;
		logic               sv;
		logic        [7:0]  sa;
	} tilt_row_t;

	typedef struct {
		logic signed [17:0] pitch;
		logic signed [15:0] roll;
		logic               sv;
		logic        [7:0]  sa;
	} tilt_res_t;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	atl_smp_if smp ();
	atl_res_if res ();
	atl_cfg_if cfg ();

	accel_tilt_angles uut (.clk(clk), .arst_n(arst_n), .smp(smp), .res(res), .cfg(cfg));

	tilt_res_t   angles_due[$];
	logic [7:0]  mount_offset = 8'(atl_pkg::OFFSET_RESET);
	int          errors = 0;
	int          idle_cycles = 0;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	longint      atan_q24 [0:atl_pkg::MAX_STAGES-1];

	initial begin
		smp.valid = 0; smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
		res.ready = 0;
		cfg.valid = 0; cfg.data = '0;
		for (int i = 0; i < atl_pkg::MAX_STAGES; i++)
			atan_q24[i] = longint'(atl_pkg::ATAN_TAB[i]);
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint tilt_deg(longint num, longint a, longint b);
		longint x, y, z, xs, ys;
		x = int_sqrt(longint'(a * a + b * b) << (2 * atl_pkg::GUARD_BITS));
		y = num <<< atl_pkg::GUARD_BITS;
		z = 0;
		for (int i = 0; i < atl_pkg::CORDIC_STAGES; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += atan_q24[i];
			end else if (y < 0) begin
				x -= ys; y += xs; z -= atan_q24[i];
			end
		end
		return floor_shift(z + (64'sd1 <<< (atl_pkg::ACC_FRAC - atl_pkg::ANGLE_FRAC_BITS - 1)),
			atl_pkg::ACC_FRAC - atl_pkg::ANGLE_FRAC_BITS);
	endfunction

	function automatic tilt_res_t predict_angles(logic signed [15:0] ax, ay, az);
		tilt_res_t r;
		longint p, q;
		p = 0; q = 0;
		r.sv = 0; r.sa = 0;
		if (ax != 0 || ay != 0 || az != 0) begin
			p = tilt_deg(ax, ay, az) +
				(longint'(mount_offset) <<< atl_pkg::ANGLE_FRAC_BITS);
			q = tilt_deg(ay, ax, az);
			if (p > 0 && p < (atl_pkg::SERVO_TOP <<< atl_pkg::ANGLE_FRAC_BITS)) begin
				r.sv = 1;
				r.sa = 8'(p >>> atl_pkg::ANGLE_FRAC_BITS);
			end
		end
		r.pitch = 18'(p);
		r.roll = 16'(q);
		return r;
	endfunction

	// sample results and compare against the oldest expectation
	always @(posedge clk) begin
		tilt_res_t e;
		if (smp.valid && smp.ready || res.valid && res.ready || cfg.valid && cfg.ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && res.valid && res.ready) begin
			if (angles_due.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = angles_due.pop_front();
				if (res.pitch_q8 !== e.pitch) begin
					$error("pitch_q8 exp %0d got %0d", e.pitch, res.pitch_q8); errors++;
				end
				if (res.roll_q8 !== e.roll) begin
					$error("roll_q8 exp %0d got %0d", e.roll, res.roll_q8); errors++;
				end
				if (res.servo_valid !== e.sv) begin
					$error("servo_valid exp %0d got %0d", e.sv, res.servo_valid); errors++;
				end
				if (res.servo_angle !== e.sa) begin
					$error("servo_angle exp %0d got %0d", e.sa, res.servo_angle); errors++;
				end
			end
		end
	end

	always @(negedge clk)
		res.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk)
		if (idle_cycles > 20000) begin
			$display("CHECK FAILED");
			$finish;
		end

	// leaves valid high after the transaction; drop it while idling or draining
	task automatic send_sample(logic signed [15:0] ax, ay, az, tilt_row_t row);
		tilt_res_t e;
		while ($urandom_range(99) < src_idle_pct) begin
			smp.valid <= 0;
			@(negedge clk);
		end
		smp.valid <= 1; smp.accel_x <= ax; smp.accel_y <= ay; smp.accel_z <= az;
		e = predict_angles(ax, ay, az);
		if (row.typed) begin
			e.pitch = row.pitch; e.roll = row.roll; e.sv = row.sv; e.sa = row.sa;
		end
		do @(posedge clk); while (!smp.ready);
		angles_due.push_back(e);
		@(negedge clk);
	endtask

	task automatic drain();
		smp.valid <= 0;
		while (angles_due.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_offset(logic [7:0] v);
		drain();
		cfg.valid <= 1; cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		mount_offset = v;
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(8)) - 16'sd4;
			3: return 16'($urandom_range(600)) - 16'sd300;
			default: return 16'($urandom);
		endcase
	endfunction

	tilt_row_t dir_rows[] = '{
		'{0, 0, 0, 1, 18'sd0, 16'sd0, 1'b0, 8'd0},
		'{100, 0, 0, 1, 18'sd46080, 16'sd0, 1'b0, 8'd0},
		'{-100, 0, 0, 1, 18'sd0, 16'sd0, 1'b0, 8'd0},
		'{0, 0, 100, 1, 18'sd23040, 16'sd0, 1'b1, 8'd90},
		'{0, 500, 0, 1, 18'sd23040, 16'sd23040, 1'b1, 8'd90},
		'{0, -500, 0, 1, 18'sd23040, -16'sd23040, 1'b1, 8'd90},
		'{-32768, -32768, -32768, 0, 0, 0, 0, 0},
		'{32767, 32767, 32767, 0, 0, 0, 0, 0},
		'{32767, -32768, 1, 0, 0, 0, 0, 0},
		'{-32768, 32767, -1, 0, 0, 0, 0, 0},
		'{1, 1, 1, 0, 0, 0, 0, 0},
		'{-1, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, -32768, 0, 0, 0, 0, 0},
		'{1000, 2000, -3000, 0, 0, 0, 0, 0},
		'{-5461, 10922, 21845, 0, 0, 0, 0, 0},
		'{0, 1, 0, 0, 0, 0, 0, 0}
	};

	initial begin
		tilt_row_t none;
		none.typed = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_sample(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az, dir_rows[i]);
		// extremes of the offset, then random settings
		for (int k = 0; k < 4; k++) begin
			write_offset(k == 0 ? 8'd0 : k == 1 ? 8'd180 : k == 2 ? 8'd255 : 8'd1);
			foreach (dir_rows[i])
				send_sample(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az, none);
		end
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = ph == 0 ? 9 : ph == 1 ? 57 : 0;
			snk_idle_pct = ph == 0 ? 57 : ph == 1 ? 9 : 0;
			for (int s = 0; s < 4; s++) begin
				write_offset(8'($urandom_range(180)));
				for (int n = 0; n < 50; n++)
					send_sample(rand_axis(), rand_axis(), rand_axis(), none);
			end
		end
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/atl_pkg.sv
hw/rtl/atl_if.sv
hw/rtl/atl_sqrt.sv
hw/rtl/atl_cordic.sv
hw/rtl/accel_tilt_angles.sv
dv/testbench.sv
